### hdl/tasce_pkg.sv
// Shared types and constants for the two-axis servo cubic easing core.
// No dependencies; used by tasce_ctrl, tasce_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tasce_pkg;

    // Item kinds carried in the slave-side tuser
    localparam logic [1:0] FUNC_UPDATE  = 2'd0;
    localparam logic [1:0] FUNC_START_X = 2'd1;
    localparam logic [1:0] FUNC_START_Y = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_Y = 1'b1;

    // Field widths
    localparam int unsigned ANGLE_W  = 8;
    localparam int unsigned TARGET_W = 11;
    localparam int unsigned DUR_W    = 16;
    localparam int unsigned TIME_W   = 32;

    // Angle after reset on both axes
    localparam logic [ANGLE_W-1:0] HOME_RESET = 8'd90;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic div_step;
        logic mul_sq;
        logic mul_cube;
        logic ease;
        logic mul_x;
        logic mul_y;
        logic ang_y;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic interp;
    } t_dp_sts;

endpackage

`default_nettype wire

### hdl/tasce_ctrl.sv
// Sequencer for the easing core: accepts one item, for an interpolating update
// steps the divider and the shared multiplier, then hands the result to the output register.
// Depends on tasce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tasce_ctrl #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output      logic              o_in_ready,
    input  wire logic              i_out_ready,
    output      logic              o_out_valid,
    input  wire tasce_pkg::t_dp_sts i_sts,
    output      tasce_pkg::t_dp_cmd o_cmd
);

    localparam int unsigned CNT_W = $clog2(FRAC_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS - 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECIDE = 4'd1;
    localparam logic [3:0] ST_DIV    = 4'd2;
    localparam logic [3:0] ST_SQ     = 4'd3;
    localparam logic [3:0] ST_CUBE   = 4'd4;
    localparam logic [3:0] ST_EASE   = 4'd5;
    localparam logic [3:0] ST_MULX   = 4'd6;
    localparam logic [3:0] ST_MULY   = 4'd7;
    localparam logic [3:0] ST_ANGY   = 4'd8;
    localparam logic [3:0] ST_FIN    = 4'd9;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    tasce_pkg::t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (i_sts.interp) begin
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_SQ;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_SQ: begin
                cmd.mul_sq = 1'b1;
                n_state    = ST_CUBE;
            end
            ST_CUBE: begin
                cmd.mul_cube = 1'b1;
                n_state      = ST_EASE;
            end
            ST_EASE: begin
                cmd.ease = 1'b1;
                n_state  = ST_MULX;
            end
            ST_MULX: begin
                cmd.mul_x = 1'b1;
                n_state   = ST_MULY;
            end
            ST_MULY: begin
                cmd.mul_y = 1'b1;
                n_state   = ST_ANGY;
            end
            ST_ANGY: begin
                cmd.ang_y = 1'b1;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

`default_nettype wire

### hdl/tasce_dp.sv
// Datapath of the easing core: axis state, restoring divider for progress,
// one shared signed multiplier for the cubic ease and the interpolation.
// Depends on tasce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tasce_dp #(
    parameter int unsigned FRAC_BITS = 16,
    parameter int unsigned ANGLE_MAX = 180
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire tasce_pkg::t_dp_cmd                  i_cmd,
    output      tasce_pkg::t_dp_sts                  o_sts,
    input  wire logic [1:0]                          i_func,
    input  wire logic [tasce_pkg::TARGET_W-1:0]      i_target,
    input  wire logic [tasce_pkg::DUR_W-1:0]         i_dur,
    input  wire logic [tasce_pkg::TIME_W-1:0]        i_now,
    input  wire logic                                i_cfg_we,
    input  wire logic [tasce_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [tasce_pkg::ANGLE_W-1:0]       i_cfg_data,
    output      logic [tasce_pkg::ANGLE_W-1:0]       o_angle_x,
    output      logic [tasce_pkg::ANGLE_W-1:0]       o_angle_y,
    output      logic                                o_moving_x,
    output      logic                                o_moving_y,
    output      logic                                o_interp
);

    localparam int unsigned AW = tasce_pkg::ANGLE_W;
    localparam int unsigned DW = tasce_pkg::DUR_W;
    localparam int unsigned TW = tasce_pkg::TIME_W;
    localparam int unsigned F  = FRAC_BITS;
    localparam int unsigned MW = F + 2;      // multiplier operand width
    localparam int unsigned PW = 2 * MW;     // product width
    localparam int unsigned TARGET_MSB = tasce_pkg::TARGET_W - 1;
    localparam logic [AW-1:0] ANG_MAX = AW'(ANGLE_MAX);
    localparam logic [F:0]    ONE_E   = {1'b1, {F{1'b0}}};

    // Axis state
    logic [AW-1:0] r_cur_x, r_cur_y, r_from_x, r_from_y, r_goal_x, r_goal_y;
    logic          r_busy_x, r_busy_y;
    logic [TW-1:0] r_move_start;
    logic [DW-1:0] r_move_len;

    // Working registers
    logic [DW-1:0]        r_rem;
    logic [F-1:0]         r_q;
    logic [F:0]           r_e;
    logic signed [PW-1:0] r_prod;
    logic                 r_ix, r_iy;

    // Result register
    logic [AW-1:0] r_out_ax, r_out_ay;
    logic          r_out_mx, r_out_my, r_out_int;

    logic [AW-1:0]        tgt, cfg_sat;
    logic [TW-1:0]        elapsed;
    logic                 lt;
    logic [DW:0]          rem2;
    logic                 ge;
    logic [DW:0]          rem_sub;
    logic [F:0]           v_full, k, e_next;
    logic [F-1:0]         s;
    logic signed [8:0]    d_x, d_y;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic signed [9:0]    step;
    logic [9:0]           ang_x, ang_y;

    // Target clamp: negative to zero, large to the maximum
    always_comb begin
        if (i_target[TARGET_MSB]) begin
            tgt = '0;
        end else if (i_target[TARGET_MSB-1:0] > {2'b00, ANG_MAX}) begin
            tgt = ANG_MAX;
        end else begin
            tgt = i_target[AW-1:0];
        end
    end

    assign cfg_sat = (i_cfg_data > ANG_MAX) ? ANG_MAX : i_cfg_data;
    assign elapsed = i_now - r_move_start;
    assign lt      = (elapsed < {{(TW-DW){1'b0}}, r_move_len});

    // Restoring divide, one quotient bit a step
    assign rem2    = {r_rem, 1'b0};
    assign ge      = (rem2 >= {1'b0, r_move_len});
    assign rem_sub = rem2 - {1'b0, r_move_len};

    // Ease terms; upper half of the curve mirrors around t = 1/2
    assign v_full = r_q[F-1] ? (ONE_E - {1'b0, r_q}) : {1'b0, r_q};
    assign s      = r_prod[2*F-1:F];
    assign k      = r_prod[2*F-2:F-2];
    assign e_next = r_q[F-1] ? (ONE_E - k) : k;

    assign d_x = signed'({1'b0, r_goal_x}) - signed'({1'b0, r_from_x});
    assign d_y = signed'({1'b0, r_goal_y}) - signed'({1'b0, r_from_y});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.mul_sq) begin
            mul_a = signed'({1'b0, v_full});
            mul_b = signed'({1'b0, v_full});
        end else if (i_cmd.mul_cube) begin
            mul_a = signed'({2'b00, s});
            mul_b = signed'({1'b0, v_full});
        end else if (i_cmd.mul_x) begin
            mul_a = signed'({{(MW-9){d_x[8]}}, d_x});
            mul_b = signed'({1'b0, r_e});
        end else if (i_cmd.mul_y) begin
            mul_a = signed'({{(MW-9){d_y[8]}}, d_y});
            mul_b = signed'({1'b0, r_e});
        end
    end

    assign prod = mul_a * mul_b;

    // from + floor(d*e / ONE)
    assign step  = r_prod[F+9:F];
    assign ang_x = 10'({2'b00, r_from_x}) + 10'(step);
    assign ang_y = 10'({2'b00, r_from_y}) + 10'(step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x      <= tasce_pkg::HOME_RESET;
            r_cur_y      <= tasce_pkg::HOME_RESET;
            r_from_x     <= '0;
            r_from_y     <= '0;
            r_goal_x     <= '0;
            r_goal_y     <= '0;
            r_busy_x     <= 1'b0;
            r_busy_y     <= 1'b0;
            r_move_start <= '0;
            r_move_len   <= '0;
            r_ix         <= 1'b0;
            r_iy         <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_ix <= 1'b0;
                r_iy <= 1'b0;
                case (i_func)
                    tasce_pkg::FUNC_START_X: begin
                        r_from_x     <= r_cur_x;
                        r_goal_x     <= tgt;
                        r_move_len   <= i_dur;
                        r_move_start <= i_now;
                        r_busy_x     <= 1'b1;
                    end
                    tasce_pkg::FUNC_START_Y: begin
                        r_from_y     <= r_cur_y;
                        r_goal_y     <= tgt;
                        r_move_len   <= i_dur;
                        r_move_start <= i_now;
                        r_busy_y     <= 1'b1;
                    end
                    tasce_pkg::FUNC_UPDATE: begin
                        if (lt) begin
                            r_ix <= r_busy_x;
                            r_iy <= r_busy_y;
                        end else begin
                            // time is up: snap to goal
                            if (r_busy_x) begin
                                r_cur_x  <= r_goal_x;
                                r_busy_x <= 1'b0;
                            end
                            if (r_busy_y) begin
                                r_cur_y  <= r_goal_y;
                                r_busy_y <= 1'b0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.mul_y && r_ix) begin
                r_cur_x <= ang_x[AW-1:0];
            end
            if (i_cmd.ang_y && r_iy) begin
                r_cur_y <= ang_y[AW-1:0];
            end
            if (i_cfg_we) begin
                if (i_cfg_index == tasce_pkg::CFG_HOME_X && !r_busy_x) begin
                    r_cur_x <= cfg_sat;
                end
                if (i_cfg_index == tasce_pkg::CFG_HOME_Y && !r_busy_y) begin
                    r_cur_y <= cfg_sat;
                end
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= elapsed[DW-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? rem_sub[DW-1:0] : rem2[DW-1:0];
        end
        if (i_cmd.div_step) begin
            r_q <= {r_q[F-2:0], ge};
        end
        if (i_cmd.mul_sq || i_cmd.mul_cube || i_cmd.mul_x || i_cmd.mul_y) begin
            r_prod <= prod;
        end
        if (i_cmd.ease) begin
            r_e <= e_next;
        end
        if (i_cmd.out_load) begin
            r_out_ax  <= r_cur_x;
            r_out_ay  <= r_cur_y;
            r_out_mx  <= r_busy_x;
            r_out_my  <= r_busy_y;
            r_out_int <= r_ix | r_iy;
        end
    end

    assign o_sts.interp = r_ix | r_iy;
    assign o_angle_x    = r_out_ax;
    assign o_angle_y    = r_out_ay;
    assign o_moving_x   = r_out_mx;
    assign o_moving_y   = r_out_my;
    assign o_interp     = r_out_int;

endmodule

`default_nettype wire

### hdl/two_axis_servo_cubic_easing_core.sv
// Two-axis servo angle generator with cubic ease-in-out, top level.
// Depends on tasce_pkg, tasce_ctrl and tasce_dp.
//
// Use:
//  - Slave stream: tuser carries the item kind (update tick, start X, start Y);
//    tdata carries target angle, duration and the millisecond time stamp.
//  - Master stream: one result transaction per input transaction, with both
//    angles, both moving flags and the interpolation flag.
//  - Config channel: i_cfg_index selects home X or home Y; a write saturates
//    to ANGLE_MAX and moves the axis there if it is not mid-movement. Only
//    write while the core is idle. o_cfg_ready is always high.
// Timing:
//  - One item at a time. An interpolating update passes through the decide step,
//    the restoring divider, which yields one progress bit per cycle, and six steps
//    (square, cube, ease, multiply X, multiply Y, angle Y); square, cube and the
//    X and Y multiplies go through the single shared multiplier. The final step then
//    loads the output register; other items skip straight to the final step.
//  - The result sits in an output register, so a new item is taken while the
//    previous result is still waiting; the core only holds in its last step
//    if the receiver has not yet taken the previous result.
// Reset: synchronous, active low. Both angles return to 90, both axes idle,
//  start time and duration cleared, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module two_axis_servo_cubic_easing_core #(
    parameter int unsigned FRAC_BITS = 16,
    parameter int unsigned ANGLE_MAX = 180
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Slave stream
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // target_angle[10:0], duration_ms[26:11],
                                            // now_ms[58:27], zero pad[63:59]
    input  wire logic [1:0]  s_axis_tuser,  // func[1:0]
    // Master stream
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [23:0] m_axis_tdata,  // angle_x[7:0], angle_y[15:8], moving_x[16],
                                            // moving_y[17], any_interpolating[18], zero[23:19]
    // Configuration writes
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [tasce_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tasce_pkg::ANGLE_W-1:0]   i_cfg_data
);

    tasce_pkg::t_dp_cmd cmd;
    tasce_pkg::t_dp_sts sts;

    logic [tasce_pkg::ANGLE_W-1:0] angle_x, angle_y;
    logic                          moving_x, moving_y, interp;
    logic                          cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    tasce_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tasce_dp #(
        .FRAC_BITS (FRAC_BITS),
        .ANGLE_MAX (ANGLE_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_func      (s_axis_tuser),
        .i_target    (s_axis_tdata[10:0]),
        .i_dur       (s_axis_tdata[26:11]),
        .i_now       (s_axis_tdata[58:27]),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_angle_x   (angle_x),
        .o_angle_y   (angle_y),
        .o_moving_x  (moving_x),
        .o_moving_y  (moving_y),
        .o_interp    (interp)
    );

    assign m_axis_tdata = {5'b00000, interp, moving_y, moving_x, angle_y, angle_x};

    // After a transaction in, the core is not ready again in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while previous item still in progress");

    // An interpolated result always leaves an axis still moving
    a_interp_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[18]) |-> (m_axis_tdata[16] || m_axis_tdata[17]))
        else $error("interpolation flagged with both axes idle");

    // A new result only appears after an item was in progress
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result raised without an item in progress");

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for two_axis_servo_cubic_easing_core: directed and random
// start/update streams, home register writes and ready/valid idling, checked by a scoreboard.
// Depends on tasce_pkg and two_axis_servo_cubic_easing_core.
`timescale 1ns / 1ps

localparam int unsigned   EASE_FRAC   = 16;
localparam int unsigned   ANGLE_LIM   = 180;
localparam logic [63:0]   EASE_ONE    = 64'd1 << EASE_FRAC;
localparam logic [63:0]   EASE_HALF   = 64'd1 << (EASE_FRAC - 1);
localparam logic [1:0]    FUNC_UNUSED = 2'd3;
localparam int unsigned   AXIS_X      = 0;
localparam int unsigned   AXIS_Y      = 1;

// Result transaction, lowest field last
typedef struct packed {
    logic [4:0] pad;
    logic       interp;
    logic       moving_y;
    logic       moving_x;
    logic [7:0] angle_y;
    logic [7:0] angle_x;
} t_servo_result;

class servo_scoreboard;
    logic [7:0]    cur_angle  [2];
    logic [7:0]    from_angle [2];
    logic [7:0]    goal_angle [2];
    logic          busy       [2];
    logic [31:0]   move_start;
    logic [15:0]   move_len;
    t_servo_result pending [$];
    int unsigned   n_items, n_checked, n_interp, n_snaps, n_cfg, n_errors;

    function new();
        for (int a = 0; a < 2; a++) begin
            cur_angle[a]  = tasce_pkg::HOME_RESET;
            from_angle[a] = '0;
            goal_angle[a] = '0;
            busy[a]       = 1'b0;
        end
        move_start = '0;
        move_len   = '0;
    endfunction

    // Negative targets go to zero, large ones to the top of the range
    function logic [7:0] clamp_angle(logic [10:0] v);
        if (v[10])
            return 8'd0;
        if (v > ANGLE_LIM)
            return 8'(ANGLE_LIM);
        return v[7:0];
    endfunction

    // Cubic ease-in-out between the start and goal angles, floored
    function logic [7:0] eased_angle(logic [7:0] from, logic [7:0] goal, logic [31:0] elapsed);
        logic [63:0] t, s, u, e, mix;
        t = ({32'd0, elapsed} << EASE_FRAC) / {48'd0, move_len};
        if (t < EASE_HALF) begin
            s = (t * t) >> EASE_FRAC;
            e = (4 * s * t) >> EASE_FRAC;
        end else begin
            u = EASE_ONE - t;
            s = (u * u) >> EASE_FRAC;
            e = EASE_ONE - ((4 * s * u) >> EASE_FRAC);
        end
        mix = ({56'd0, from} * (EASE_ONE - e) + {56'd0, goal} * e) >> EASE_FRAC;
        return mix[7:0];
    endfunction

    function void write_home(logic [tasce_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
        logic [7:0] v;
        v = clamp_angle({3'd0, data});
        if (!busy[idx])
            cur_angle[idx] = v;
        n_cfg++;
    endfunction

    function void note_item(logic [1:0] func, logic [10:0] target, logic [15:0] dur,
                            logic [31:0] now);
        t_servo_result r;
        logic [31:0]   elapsed;
        int unsigned   ax;
        logic          interp;
        interp = 1'b0;
        if (func == tasce_pkg::FUNC_START_X || func == tasce_pkg::FUNC_START_Y) begin
            ax = (func == tasce_pkg::FUNC_START_X) ? AXIS_X : AXIS_Y;
            from_angle[ax] = cur_angle[ax];
            goal_angle[ax] = clamp_angle(target);
            busy[ax]       = 1'b1;
            move_len       = dur;
            move_start     = now;
        end else if (func == tasce_pkg::FUNC_UPDATE) begin
            elapsed = now - move_start;
            for (int a = 0; a < 2; a++) begin
                if (busy[a]) begin
                    if (elapsed < {16'd0, move_len}) begin
                        cur_angle[a] = eased_angle(from_angle[a], goal_angle[a], elapsed);
                        interp = 1'b1;
                    end else begin
                        cur_angle[a] = goal_angle[a];
                        busy[a]      = 1'b0;
                        n_snaps++;
                    end
                end
            end
        end
        r          = '0;
        r.angle_x  = cur_angle[AXIS_X];
        r.angle_y  = cur_angle[AXIS_Y];
        r.moving_x = busy[AXIS_X];
        r.moving_y = busy[AXIS_Y];
        r.interp   = interp;
        if (interp)
            n_interp++;
        pending.push_back(r);
        n_items++;
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            n_errors++;
        end
    endfunction

    function void check_result(logic [23:0] raw);
        t_servo_result got, want;
        got = t_servo_result'(raw);
        if (pending.size() == 0) begin
            $error("result %h arrived with no transaction outstanding", raw);
            n_errors++;
            return;
        end
        want = pending.pop_front();
        n_checked++;
        compare("angle_x", want.angle_x, got.angle_x);
        compare("angle_y", want.angle_y, got.angle_y);
        compare("moving_x", want.moving_x, got.moving_x);
        compare("moving_y", want.moving_y, got.moving_y);
        compare("any_interpolating", want.interp, got.interp);
    endfunction
endclass

module testbench;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [63:0]                     s_axis_tdata  = '0;
    logic [1:0]                      s_axis_tuser  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [23:0]                     m_axis_tdata;
    logic                            i_cfg_valid   = 1'b0;
    logic                            o_cfg_ready;
    logic [tasce_pkg::CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [tasce_pkg::ANGLE_W-1:0]   i_cfg_data    = '0;

    servo_scoreboard sb;

    int unsigned send_idle_pct     = 0;
    int unsigned recv_stall_pct    = 0;
    int unsigned hold_cycles_left  = 0;
    int unsigned items_sent        = 0;
    logic [31:0] clock_ms          = '0;

    two_axis_servo_cubic_easing_core #(
        .FRAC_BITS (EASE_FRAC),
        .ANGLE_MAX (ANGLE_LIM)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Watchdog
    initial begin
        #8_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Sample every handshake at the rising edge; home writes, then results before new
    // items, as a result can never belong to a transaction accepted on the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_home(i_cfg_index, i_cfg_data);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_item(s_axis_tuser, s_axis_tdata[10:0], s_axis_tdata[26:11],
                             s_axis_tdata[58:27]);
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_cycles_left != 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic [1:0] func, input logic [10:0] target,
                             input logic [15:0] dur, input logic [31:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {5'd0, now, dur, target};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (func != FUNC_UNUSED)
            items_sent++;
        @(negedge i_clk);
    endtask

    // Let every outstanding result come back, then a margin for the datapath
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_homes(input logic [7:0] x, input logic [7:0] y);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= tasce_pkg::CFG_HOME_X;
        i_cfg_data  <= x;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_index <= tasce_pkg::CFG_HOME_Y;
        i_cfg_data  <= y;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_duration();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return 16'd0;
        if (r < 14)
            return 16'($urandom_range(1, 3));
        if (r < 92)
            return 16'($urandom_range(20, 1500));
        if (r < 97)
            return 16'($urandom_range(1501, 65534));
        return 16'hFFFF;
    endfunction

    function automatic logic [10:0] pick_target();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return 11'($urandom_range(0, ANGLE_LIM));
        if (r < 78)
            return 11'($urandom_range(ANGLE_LIM + 1, 1023));
        if (r < 88)
            return 11'($urandom_range(1024, 2047));    // negative
        if (r < 94)
            return 11'd0;
        return 11'(ANGLE_LIM);
    endfunction

    // One movement: start an axis, then update ticks across the whole move and a
    // little past it. Sometimes the other axis starts midway and retimes both.
    // A few sequences are plain noise: random codes, fields and time stamps.
    task automatic run_motion();
        int unsigned r, hop, span, elapsed;
        logic [15:0] dur;
        logic [1:0]  first_axis, other_axis;
        logic        second_start;
        r = $urandom_range(99);
        if (r < 10) begin
            repeat ($urandom_range(1, 4))
                send_item(2'($urandom_range(3)), 11'($urandom), 16'($urandom), $urandom);
            return;
        end
        dur          = pick_duration();
        first_axis   = $urandom_range(1) ? tasce_pkg::FUNC_START_X : tasce_pkg::FUNC_START_Y;
        other_axis   = (first_axis == tasce_pkg::FUNC_START_X) ? tasce_pkg::FUNC_START_Y
                                                               : tasce_pkg::FUNC_START_X;
        second_start = ($urandom_range(99) < 30);
        send_item(first_axis, pick_target(), dur, clock_ms);
        span    = dur + $urandom_range(0, dur / 4 + 2);
        elapsed = 0;
        while (elapsed <= span) begin
            hop = dur / $urandom_range(3, 25) + $urandom_range(0, 3);
            if (hop == 0)
                hop = 1;
            clock_ms += hop;
            elapsed  += hop;
            // target and duration are don't-care on updates: fill with noise
            send_item(tasce_pkg::FUNC_UPDATE, 11'($urandom), 16'($urandom), clock_ms);
            if (second_start && elapsed > dur / 3) begin
                second_start = 1'b0;
                send_item(other_axis, pick_target(), dur, clock_ms);
                elapsed = 0;
            end
        end
    endtask

    initial begin
        int unsigned phase_end;
        bit          hold_done;
        logic [7:0]  hx, hy;
        sb        = new();
        hold_done = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset homes, ignored code, clamping, ease halves, zero and
        // one-millisecond durations, retiming, time wrap, stamp before start
        send_item(tasce_pkg::FUNC_UPDATE,  11'h7FF, 16'hFFFF, 32'd0);
        send_item(FUNC_UNUSED,             11'h7FF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(tasce_pkg::FUNC_START_X, 11'h400, 16'd100, 32'd1000);
        send_item(tasce_pkg::FUNC_UPDATE,  11'h000, 16'h0000, 32'd1025);
        send_item(tasce_pkg::FUNC_UPDATE,  11'h000, 16'h0000, 32'd1050);   // exactly half way
        send_item(tasce_pkg::FUNC_UPDATE,  11'h000, 16'h0000, 32'd1075);
        send_item(tasce_pkg::FUNC_UPDATE,  11'h000, 16'h0000, 32'd1100);   // reaches the goal
        send_item(tasce_pkg::FUNC_START_Y, 11'h3FF, 16'd0, 32'd5000);
        send_item(tasce_pkg::FUNC_UPDATE,  11'h000, 16'h0000, 32'd5000);   // zero duration snaps
        send_item(tasce_pkg::FUNC_START_X, 11'd180, 16'hFFFF, 32'hFFFF_FFF0);
        send_item(tasce_pkg::FUNC_UPDATE,  11'h000, 16'h0000, 32'h0000_0100);  // across the wrap
        send_item(tasce_pkg::FUNC_START_Y, 11'd45,  16'd200, 32'h0000_0200);   // retimes X
        send_item(tasce_pkg::FUNC_UPDATE,  11'h000, 16'h0000, 32'h0000_0250);
        send_item(tasce_pkg::FUNC_UPDATE,  11'h000, 16'h0000, 32'h0000_02C8);
        send_item(tasce_pkg::FUNC_START_X, 11'h7FF, 16'd1, 32'd10);
        send_item(tasce_pkg::FUNC_UPDATE,  11'h000, 16'h0000, 32'd10);
        send_item(tasce_pkg::FUNC_UPDATE,  11'h000, 16'h0000, 32'd11);
        send_item(tasce_pkg::FUNC_START_Y, 11'd181, 16'd3, 32'd20);
        send_item(tasce_pkg::FUNC_UPDATE,  11'h000, 16'h0000, 32'd21);
        send_item(tasce_pkg::FUNC_UPDATE,  11'h000, 16'h0000, 32'd22);
        send_item(tasce_pkg::FUNC_UPDATE,  11'h000, 16'h0000, 32'd19);     // stamp before start

        for (int phase = 0; phase < 4; phase++) begin
            drain();
            case (phase)
                0: begin hx = 8'd0;   hy = 8'd255; end
                1: begin hx = 8'd181; hy = 8'd180; end
                2: begin hx = 8'($urandom); hy = 8'($urandom); end
                default: begin hx = 8'd255; hy = 8'd0; end
            endcase
            write_homes(hx, hy);
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            clock_ms  = (phase == 1) ? 32'hFFFF_F000 : $urandom;
            phase_end = items_sent + 440;
            while (items_sent < phase_end) begin
                run_motion();
                // Receiver goes quiet while the sender keeps offering
                if (phase == 0 && !hold_done && items_sent + 250 >= phase_end) begin
                    hold_cycles_left = 300;
                    hold_done        = 1'b1;
                end
            end
            // Leave one axis mid-move so the next home write finds it busy
            send_item($urandom_range(1) ? tasce_pkg::FUNC_START_X : tasce_pkg::FUNC_START_Y,
                      pick_target(), 16'd60000, clock_ms);
        end

        drain();
        $display("Covered %0d transactions over four idling phases and a long hold-off:",
                 sb.n_items);
        $display("%0d results checked, %0d interpolated, %0d snaps, %0d home writes.",
                 sb.n_checked, sb.n_interp, sb.n_snaps, sb.n_cfg);
        if (sb.n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
